/* hdl/bdascii_pkg.sv */
// shared types and constants for the binary to decimal ascii converter
package bdascii_pkg;

    localparam int MAX_DIGITS = 20;
    localparam int HARD_CAP   = 20;
    // digit count actually kept: a 64-bit value never needs more than twenty
    localparam int DIGITS     = (MAX_DIGITS > HARD_CAP) ? HARD_CAP :
                                ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
    localparam int VALUE_W    = 64;
    localparam int BCD_W      = DIGITS * 4;
    localparam int POS_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int ITER_W     = $clog2(VALUE_W);
    localparam int CHAR_W     = 6;

    localparam logic [ITER_W-1:0] ITER_LAST  = ITER_W'(VALUE_W - 1);
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_LOCATE,
        S_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic locate;
        logic advance;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic pos_zero;
    } t_dp_sts;

endpackage

/* hdl/binary_to_decimal_ascii.sv */
// top level: 64-bit unsigned value to decimal ascii digit words
// one word in, then shift and add-three conversion steps on a bcd register,
// a search for the leading digit, then one digit word per cycle while i_ready is high (1 to 20 words)
// the first digit shows once the leading digit is found; input ready again
// the cycle after the last digit is taken, and no new word is taken before then
// synchronous active low reset returns the controller to idle; no memories to clear
module binary_to_decimal_ascii
    import bdascii_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // control
    bdascii_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // datapath
    bdascii_datapath u_dp (
        .i_clk        (i_clk),
        .i_value      (i_value),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_digit_char (o_digit_char)
    );

    assign o_last = dp_sts.pos_zero;

endmodule

/* hdl/bdascii_datapath.sv */
// double dabble shift register, leading digit search and digit select
module bdascii_datapath
    import bdascii_pkg::*;
(
    input  logic                i_clk,
    input  logic [VALUE_W-1:0]  i_value,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic [CHAR_W-1:0]   o_digit_char
);

    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [BCD_W-1:0]   adj_bcd;
    logic [POS_W-1:0]   top_pos;
    logic [3:0]         sel_digit;

    // add three to every bcd digit of five or more
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj_bcd[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                adj_bcd[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // position of the most significant nonzero digit, zero if all are zero
    always_comb begin
        top_pos = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                top_pos = POS_W'(i);
            end
        end
    end

    // next values of the working registers
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_pos = r_pos;
        if (i_cmd.load) begin
            n_bin = i_value;
            n_bcd = '0;
        end else if (i_cmd.step) begin
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_bcd = {adj_bcd[BCD_W-2:0], r_bin[VALUE_W-1]};
        end
        if (i_cmd.locate) begin
            n_pos = top_pos;
        end else if (i_cmd.advance) begin
            n_pos = r_pos - POS_W'(1);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_pos <= n_pos;
    end

    // current digit as ascii
    assign sel_digit      = r_bcd[r_pos*4 +: 4];
    assign o_digit_char   = ASCII_ZERO | {{(CHAR_W-4){1'b0}}, sel_digit};
    assign o_sts.pos_zero = (r_pos == '0);

endmodule

/* hdl/bdascii_ctrl.sv */
// controller state machine: accept, convert, locate, emit
module bdascii_ctrl
    import bdascii_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    // state and iteration counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (r_iter == ITER_LAST) begin
                    n_state = S_LOCATE;
                end
            end
            S_LOCATE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready && i_sts.pos_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and counter
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        n_iter      = r_iter;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                n_iter     = '0;
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                n_iter     = r_iter + ITER_W'(1);
            end
            S_LOCATE: begin
                o_cmd.locate = 1'b1;
            end
            S_EMIT: begin
                o_out_valid   = 1'b1;
                o_cmd.advance = i_out_ready && !i_sts.pos_zero;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/bdascii_checker.sv */
// port level checks for the converter and their binding to the top level
module bdascii_checker
    import bdascii_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [CHAR_W-1:0]  o_digit_char,
    input logic               o_last
);

    // every shown word is a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= 6'd48) && (o_digit_char <= 6'd57))
        else $error("digit out of range");

    // no new input word while digits are being shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready during emission");

    // busy right after an input word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready && !o_valid)
        else $error("not busy after accept");

    // run ends after the last digit is taken
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> !o_valid && o_ready)
        else $error("emission continues past last digit");

    // stalled output word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_digit_char) && $stable(o_last))
        else $error("stalled word changed");

endmodule

bind binary_to_decimal_ascii bdascii_checker u_bdascii_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_digit_char (o_digit_char),
    .o_last       (o_last)
);

/* tb/tb.sv */
// testbench for the binary to decimal ascii converter: predicted digit words checked in order
module tb
    import bdascii_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               RUN_LIMIT  = 400000;
    localparam int               RAND_ITEMS = 47;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);

    // scoreboard: expected digit words, oldest first
    class digit_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] ch;
            logic              last;
        } t_digit_word;

        t_digit_word pending[$];
        int          n_errors = 0;

        task report(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            n_errors++;
        endtask

        // split the value into decimal digits and queue them msd first
        function void note_value(input logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] rem;
            int                 low_first[DIGITS];
            int                 count;
            t_digit_word        w;
            rem   = v;
            count = 0;
            if (rem == '0) begin
                low_first[0] = 0;
                count        = 1;
            end else begin
                while (rem != '0 && count < DIGITS) begin
                    low_first[count] = int'(rem % 64'd10);
                    rem              = rem / 64'd10;
                    count++;
                end
            end
            for (int k = 0; k < count; k++) begin
                w.ch   = CHAR_W'(low_first[count - 1 - k]) + CHAR_ZERO;
                w.last = (k == count - 1);
                pending.push_back(w);
            end
        endfunction

        // compare one received digit word against the oldest expectation
        task check_digit(input logic [CHAR_W-1:0] ch, input logic last);
            t_digit_word w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected digit word char=%0d last=%0b", ch, last));
            end else begin
                w = pending.pop_front();
                if (ch !== w.ch)
                    report($sformatf("digit char %0d, wanted %0d", ch, w.ch));
                if (last !== w.last)
                    report($sformatf("last flag %0b, wanted %0b (char %0d)", last, w.last, w.ch));
            end
        endtask
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [VALUE_W-1:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [CHAR_W-1:0]  o_digit_char;
    logic               o_last;

    digit_scoreboard sb = new;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_len       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    binary_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_digit_char(o_digit_char),
        .o_last      (o_last)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // digit sink: check accepted words, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_digit(o_digit_char, o_last);
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [VALUE_W-1:0] pow10(input int k);
        logic [VALUE_W-1:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // random values spread over digit counts and edge regions
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(6))
            0: ;
            1: v = v >> $urandom_range(63);
            2: v = VALUE_W'($urandom_range(1000));
            3: v = pow10($urandom_range(1, 19)) + VALUE_W'($urandom_range(2)) - 64'd1;
            4: v = '1 - VALUE_W'($urandom_range(100));
            5: begin
                v = '0;
                repeat ($urandom_range(1, 19))
                    v = v * 64'd10 + VALUE_W'($urandom_range(9));
            end
            default: v = ($urandom_range(3) == 0) ? '0 : v >> $urandom_range(40, 63);
        endcase
        return v;
    endfunction

    // offer one value word and wait for it to be taken
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_value(v);
    endtask

    // stop sending until every expected digit has come back
    task automatic wait_drain();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // ask the sink to hold ready low for a stretch
    task automatic hold_receiver(input int cycles);
        hold_len  <= cycles;
        hold_reqs <= hold_reqs + 1;
    endtask

    initial begin
        logic [VALUE_W-1:0] directed[$];
        int                 send_pct[4];
        int                 recv_pct[4];

        send_pct = '{0, 74, 0, 32};
        recv_pct = '{0, 0, 74, 32};
        directed = {64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd255,
                    64'hFFFF_FFFF, 64'h1_0000_0000, pow10(9), pow10(10) - 64'd1,
                    pow10(18), pow10(19) - 64'd1, pow10(19), 64'h7FFF_FFFF_FFFF_FFFF,
                    64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h5555_5555_5555_5555, 64'd1234567890123456789, 64'd9876543210};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed values, no idling
        set_idling(0, 0);
        foreach (directed[i])
            send_value(directed[i]);
        wait_drain();

        // random values across the idling phases
        for (int p = 0; p < 4; p++) begin
            set_idling(send_pct[p], recv_pct[p]);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if ((p == 0 && n == 10) || (p == 2 && n == 20))
                    hold_receiver(500);
                if (n == 35)
                    wait_drain();
                send_value(rand_value());
            end
            wait_drain();
        end

        repeat (30) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
